FILE: hdl/awvn_pkg.sv
// ---------------------------------------------------------------------------
// awvn_pkg
// Shared types and constants of the area-weighted vertex normal block.
// ---------------------------------------------------------------------------
package awvn_pkg;

    localparam int INDEX_BITS    = 10;
    localparam int IN_COORD_BITS = 24;
    localparam int SUM_BITS      = 56;
    localparam int Q15_BITS      = 16;
    localparam int NUM_PRODUCTS  = 6;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 16;

    typedef enum logic [1:0] {
        CMD_SET_POS     = 2'd0,
        CMD_DISPLACE    = 2'd1,
        CMD_ADD_FACE    = 2'd2,
        CMD_READ_NORMAL = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        CORNER_A = 2'd0,
        CORNER_B = 2'd1,
        CORNER_C = 2'd2
    } corner_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_P_RD,
        ST_P_WR,
        ST_F_RA,
        ST_F_RB,
        ST_F_RC,
        ST_F_LC,
        ST_F_DIFF,
        ST_F_MUL,
        ST_F_CROSS,
        ST_F_SRD,
        ST_F_SWR,
        ST_N_RD,
        ST_N_LOAD,
        ST_N_NORM,
        ST_N_SQ,
        ST_N_RINIT,
        ST_N_SQRT,
        ST_N_DINIT,
        ST_N_DIV,
        ST_N_DSTORE,
        ST_N_OUT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    pos_rd;
        logic    sum_rd;
        corner_t corner;
        logic    pos_latch;
        corner_t latch_corner;
        logic    pos_wr;
        logic    diff_en;
        logic    mul_en;
        logic    cross_en;
        logic    sum_acc_wr;
        logic    norm_load;
        logic    norm_step;
        logic    sq_en;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    div_init;
        logic    div_step;
        logic    div_store;
        logic    out_load;
    } awvn_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      a_ok;
        logic      face_ok;
        logic      mul_last;
        logic      norm_done;
        logic      zero;
        logic      sq_last;
        logic      sqrt_last;
        logic      div_last;
        logic      comp_last;
        logic      out_full;
    } awvn_stat_t;

endpackage

FILE: hdl/awvn_ctrl.sv
// ---------------------------------------------------------------------------
// awvn_ctrl
// Sequencer: steps each command one micro-step a cycle; waits on full output.
// ---------------------------------------------------------------------------
module awvn_ctrl import awvn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  awvn_stat_t stat,
    output awvn_cmd_t  ctl
);

    state_t  state_reg, state_next;
    corner_t corner_reg, corner_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= CORNER_A;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        ctl         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.cmd)
                    CMD_SET_POS, CMD_DISPLACE:
                        state_next = stat.a_ok ? ST_P_RD : ST_IDLE;
                    CMD_ADD_FACE:
                        state_next = stat.face_ok ? ST_F_RA : ST_IDLE;
                    default:
                        state_next = stat.a_ok ? ST_N_RD : ST_N_OUT;
                endcase
            end
            ST_P_RD:
            begin
                ctl.pos_rd = 1'b1;
                ctl.corner = CORNER_A;
                state_next = ST_P_WR;
            end
            ST_P_WR:
            begin
                ctl.pos_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_F_RA:
            begin
                ctl.pos_rd = 1'b1;
                ctl.corner = CORNER_A;
                state_next = ST_F_RB;
            end
            ST_F_RB:
            begin
                ctl.pos_rd       = 1'b1;
                ctl.corner       = CORNER_B;
                ctl.pos_latch    = 1'b1;
                ctl.latch_corner = CORNER_A;
                state_next       = ST_F_RC;
            end
            ST_F_RC:
            begin
                ctl.pos_rd       = 1'b1;
                ctl.corner       = CORNER_C;
                ctl.pos_latch    = 1'b1;
                ctl.latch_corner = CORNER_B;
                state_next       = ST_F_LC;
            end
            ST_F_LC:
            begin
                ctl.pos_latch    = 1'b1;
                ctl.latch_corner = CORNER_C;
                state_next       = ST_F_DIFF;
            end
            ST_F_DIFF:
            begin
                ctl.diff_en = 1'b1;
                state_next  = ST_F_MUL;
            end
            ST_F_MUL:
            begin
                ctl.mul_en = 1'b1;
                if (stat.mul_last)
                    state_next = ST_F_CROSS;
            end
            ST_F_CROSS:
            begin
                ctl.cross_en = 1'b1;
                corner_next  = CORNER_A;
                state_next   = ST_F_SRD;
            end
            ST_F_SRD:
            begin
                ctl.sum_rd = 1'b1;
                ctl.corner = corner_reg;
                state_next = ST_F_SWR;
            end
            ST_F_SWR:
            begin
                ctl.sum_acc_wr = 1'b1;
                ctl.corner     = corner_reg;
                case (corner_reg)
                    CORNER_A:
                    begin
                        corner_next = CORNER_B;
                        state_next  = ST_F_SRD;
                    end
                    CORNER_B:
                    begin
                        corner_next = CORNER_C;
                        state_next  = ST_F_SRD;
                    end
                    default:
                        state_next = ST_IDLE;
                endcase
            end
            ST_N_RD:
            begin
                ctl.sum_rd = 1'b1;
                ctl.corner = CORNER_A;
                state_next = ST_N_LOAD;
            end
            ST_N_LOAD:
            begin
                ctl.norm_load = 1'b1;
                state_next    = ST_N_NORM;
            end
            ST_N_NORM:
            begin
                if (stat.zero)
                    state_next = ST_N_OUT;
                else if (stat.norm_done)
                    state_next = ST_N_SQ;
                else
                    ctl.norm_step = 1'b1;
            end
            ST_N_SQ:
            begin
                ctl.sq_en = 1'b1;
                if (stat.sq_last)
                    state_next = ST_N_RINIT;
            end
            ST_N_RINIT:
            begin
                ctl.sqrt_init = 1'b1;
                state_next    = ST_N_SQRT;
            end
            ST_N_SQRT:
            begin
                ctl.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = ST_N_DINIT;
            end
            ST_N_DINIT:
            begin
                ctl.div_init = 1'b1;
                state_next   = ST_N_DIV;
            end
            ST_N_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_N_DSTORE;
            end
            ST_N_DSTORE:
            begin
                ctl.div_store = 1'b1;
                state_next    = stat.comp_last ? ST_N_OUT : ST_N_DINIT;
            end
            ST_N_OUT:
            begin
                if (!stat.out_full)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: hdl/awvn_datapath.sv
// ---------------------------------------------------------------------------
// awvn_datapath
// Vertex tables, cross product, saturating sums, normaliser, root and divider.
// ---------------------------------------------------------------------------
module awvn_datapath import awvn_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [103:0] s_tdata,
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [63:0]  m_tdata,
    output logic         m_tuser,
    input  awvn_cmd_t    ctl,
    output awvn_stat_t   stat
);

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int MW     = (PROD_W > SUM_BITS + 1) ? PROD_W : SUM_BITS + 1;
    localparam int POS_W  = 3 * COORD_BITS;
    localparam int SV_W   = 3 * SUM_BITS;
    localparam int ADD_W  = ((IN_COORD_BITS > COORD_BITS) ? IN_COORD_BITS : COORD_BITS) + 1;
    localparam int NUM_W  = 48;

    localparam logic signed [ADD_W-1:0] POS_HI =
        ADD_W'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
    localparam logic signed [ADD_W-1:0] POS_LO = -POS_HI - ADD_W'(1);
    localparam logic signed [SUM_BITS+1:0] SUM_HI =
        (58'sd1 <<< (SUM_BITS - 1)) - 58'sd1;
    localparam logic signed [SUM_BITS+1:0] SUM_LO = -SUM_HI - 58'sd1;
    localparam logic [MW-1:0] MUL_LIM = MW'(1) << (SUM_BITS - 1);

    function automatic logic [ADDR_W-1:0] to_addr(input logic [INDEX_BITS-1:0] i);
        logic [INDEX_BITS+ADDR_W-1:0] w;
        w = {{ADDR_W{1'b0}}, i};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic in_range(input logic [INDEX_BITS-1:0] i);
        return 32'(i) < 32'(MAX_VERTICES);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_pos(
        input logic signed [ADD_W-1:0] v);
        logic signed [ADD_W-1:0] r;
        r = v;
        if (v > POS_HI)
            r = POS_HI;
        else if (v < POS_LO)
            r = POS_LO;
        return r[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [SUM_BITS-1:0] clamp_sum(
        input logic signed [SUM_BITS+1:0] v);
        logic signed [SUM_BITS+1:0] r;
        r = v;
        if (v > SUM_HI)
            r = SUM_HI;
        else if (v < SUM_LO)
            r = SUM_LO;
        return r[SUM_BITS-1:0];
    endfunction

    function automatic logic [DIFF_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic [SUM_BITS-1:0] mag_s(input logic signed [SUM_BITS-1:0] v);
        return v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
    endfunction

    // captured beat
    cmd_code_t                     cmd_reg;
    logic [INDEX_BITS-1:0]         ia_reg, ib_reg, ic_reg;
    logic signed [IN_COORD_BITS-1:0] cx_reg, cy_reg, cz_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_code_t'(s_tdata[1:0]);
            ia_reg  <= s_tdata[11:2];
            ib_reg  <= s_tdata[21:12];
            ic_reg  <= s_tdata[31:22];
            cx_reg  <= s_tdata[55:32];
            cy_reg  <= s_tdata[79:56];
            cz_reg  <= s_tdata[103:80];
        end
    end

    logic [ADDR_W-1:0] addr_a, caddr;
    logic              a_ok;

    assign addr_a = to_addr(ia_reg);
    assign a_ok   = in_range(ia_reg);

    always_comb
    begin
        case (ctl.corner)
            CORNER_A: caddr = addr_a;
            CORNER_B: caddr = to_addr(ib_reg);
            CORNER_C: caddr = to_addr(ic_reg);
            default:  caddr = addr_a;
        endcase
    end

    // position table
    logic [POS_W-1:0] pos_mem [MAX_VERTICES];
    logic [POS_W-1:0] pos_q_reg;
    logic [POS_W-1:0] pos_wdata;

    always_ff @(posedge clk)
    begin
        if (ctl.pos_rd)
            pos_q_reg <= pos_mem[caddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pos_wr)
            pos_mem[addr_a] <= pos_wdata;
    end

    logic signed [ADD_W-1:0] base_x, base_y, base_z;

    always_comb
    begin
        base_x = '0;
        base_y = '0;
        base_z = '0;
        if (cmd_reg == CMD_DISPLACE)
        begin
            base_x = ADD_W'($signed(pos_q_reg[COORD_BITS-1:0]));
            base_y = ADD_W'($signed(pos_q_reg[2*COORD_BITS-1:COORD_BITS]));
            base_z = ADD_W'($signed(pos_q_reg[3*COORD_BITS-1:2*COORD_BITS]));
        end
        pos_wdata = {clamp_pos(ADD_W'(cz_reg) + base_z),
                     clamp_pos(ADD_W'(cy_reg) + base_y),
                     clamp_pos(ADD_W'(cx_reg) + base_x)};
    end

    // face corners and edge vectors
    logic [POS_W-1:0]  pa_reg, pb_reg, pc_reg;
    logic [DIFF_W-1:0] um_reg [3];
    logic [DIFF_W-1:0] wm_reg [3];
    logic              us_reg [3];
    logic              ws_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctl.pos_latch)
        begin
            case (ctl.latch_corner)
                CORNER_A: pa_reg <= pos_q_reg;
                CORNER_B: pb_reg <= pos_q_reg;
                default:  pc_reg <= pos_q_reg;
            endcase
        end
    end

    logic signed [DIFF_W-1:0] u_d [3];
    logic signed [DIFF_W-1:0] w_d [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_d[i] = DIFF_W'($signed(pb_reg[i*COORD_BITS +: COORD_BITS]))
                   - DIFF_W'($signed(pa_reg[i*COORD_BITS +: COORD_BITS]));
            w_d[i] = DIFF_W'($signed(pc_reg[i*COORD_BITS +: COORD_BITS]))
                   - DIFF_W'($signed(pb_reg[i*COORD_BITS +: COORD_BITS]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.diff_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                um_reg[i] <= mag_d(u_d[i]);
                wm_reg[i] <= mag_d(w_d[i]);
                us_reg[i] <= u_d[i][DIFF_W-1];
                ws_reg[i] <= w_d[i][DIFF_W-1];
            end
        end
    end

    // shared multiplier, one cross product term a cycle
    logic [2:0]                mul_k_reg;
    logic signed [SUM_BITS:0]  prod_reg [NUM_PRODUCTS];
    logic [DIFF_W-1:0]         mop_u, mop_w;
    logic                      msg_u, msg_w;
    logic [PROD_W-1:0]         mprod;
    logic [MW-1:0]             mwide;
    logic [SUM_BITS-1:0]       msat;
    logic signed [SUM_BITS:0]  mres;

    always_comb
    begin
        case (mul_k_reg)
            3'd0:
            begin
                mop_u = um_reg[1]; msg_u = us_reg[1]; mop_w = wm_reg[2]; msg_w = ws_reg[2];
            end
            3'd1:
            begin
                mop_u = um_reg[2]; msg_u = us_reg[2]; mop_w = wm_reg[1]; msg_w = ws_reg[1];
            end
            3'd2:
            begin
                mop_u = um_reg[2]; msg_u = us_reg[2]; mop_w = wm_reg[0]; msg_w = ws_reg[0];
            end
            3'd3:
            begin
                mop_u = um_reg[0]; msg_u = us_reg[0]; mop_w = wm_reg[2]; msg_w = ws_reg[2];
            end
            3'd4:
            begin
                mop_u = um_reg[0]; msg_u = us_reg[0]; mop_w = wm_reg[1]; msg_w = ws_reg[1];
            end
            default:
            begin
                mop_u = um_reg[1]; msg_u = us_reg[1]; mop_w = wm_reg[0]; msg_w = ws_reg[0];
            end
        endcase
        mprod = PROD_W'(mop_u) * PROD_W'(mop_w);
        mwide = MW'(mprod);
        if (mwide > MUL_LIM)
            mwide = MUL_LIM;
        msat = mwide[SUM_BITS-1:0];
        mres = (msg_u ^ msg_w) ? -$signed({1'b0, msat}) : $signed({1'b0, msat});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_k_reg <= '0;
        else if (ctl.diff_en)
            mul_k_reg <= '0;
        else if (ctl.mul_en)
            mul_k_reg <= mul_k_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg[mul_k_reg] <= mres;
    end

    logic signed [SUM_BITS-1:0] n_reg [3];

    always_ff @(posedge clk)
    begin
        if (ctl.cross_en)
        begin
            n_reg[0] <= clamp_sum((SUM_BITS+2)'(prod_reg[0]) - (SUM_BITS+2)'(prod_reg[1]));
            n_reg[1] <= clamp_sum((SUM_BITS+2)'(prod_reg[2]) - (SUM_BITS+2)'(prod_reg[3]));
            n_reg[2] <= clamp_sum((SUM_BITS+2)'(prod_reg[4]) - (SUM_BITS+2)'(prod_reg[5]));
        end
    end

    // normal sum table
    logic [SV_W-1:0]    sum_mem [MAX_VERTICES];
    logic [SV_W-1:0]    sum_q_reg;
    logic [SV_W-1:0]    sum_wdata;
    logic [ADDR_W-1:0]  sum_waddr;
    logic               sum_we;

    always_comb
    begin
        sum_we    = ctl.pos_wr | ctl.sum_acc_wr;
        sum_waddr = ctl.pos_wr ? addr_a : caddr;
        sum_wdata = '0;
        if (!ctl.pos_wr)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_wdata[i*SUM_BITS +: SUM_BITS] = clamp_sum(
                    (SUM_BITS+2)'($signed(sum_q_reg[i*SUM_BITS +: SUM_BITS]))
                    + (SUM_BITS+2)'(n_reg[i]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_rd)
            sum_q_reg <= sum_mem[caddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[sum_waddr] <= sum_wdata;
    end

    // normaliser
    logic [SUM_BITS-1:0] t_reg [3];
    logic                sg_reg [3];
    logic [SUM_BITS-1:0] mx_reg;
    logic [SUM_BITS-1:0] lt [3];
    logic [SUM_BITS-1:0] lmx;
    logic                big;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            lt[i] = mag_s($signed(sum_q_reg[i*SUM_BITS +: SUM_BITS]));
        lmx = lt[0];
        if (lt[1] > lmx)
            lmx = lt[1];
        if (lt[2] > lmx)
            lmx = lt[2];
        big = |mx_reg[SUM_BITS-1:31];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.norm_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i]  <= lt[i];
                sg_reg[i] <= sum_q_reg[i*SUM_BITS + SUM_BITS - 1];
            end
            mx_reg <= lmx;
        end
        else if (ctl.norm_step)
        begin
            for (int i = 0; i < 3; i++)
                t_reg[i] <= big ? (t_reg[i] >> 1) : (t_reg[i] << 1);
            mx_reg <= big ? (mx_reg >> 1) : (mx_reg << 1);
        end
    end

    // sum of squares
    logic [1:0]  sq_k_reg;
    logic [61:0] sqp_reg;
    logic [63:0] acc_reg;
    logic [30:0] sq_op;

    always_comb
    begin
        case (sq_k_reg)
            2'd1:    sq_op = t_reg[1][30:0];
            2'd2:    sq_op = t_reg[2][30:0];
            default: sq_op = t_reg[0][30:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_k_reg <= '0;
        else if (ctl.norm_load)
            sq_k_reg <= '0;
        else if (ctl.sq_en)
            sq_k_reg <= sq_k_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sq_en)
        begin
            sqp_reg <= 62'(sq_op) * 62'(sq_op);
            acc_reg <= (sq_k_reg == 2'd0) ? 64'd0 : acc_reg + 64'(sqp_reg);
        end
    end

    // integer square root, one result bit a cycle
    logic [63:0] rn_reg, res_reg, bit_reg;
    logic [4:0]  sqrt_cnt_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqrt_cnt_reg <= '0;
        else if (ctl.sqrt_init)
            sqrt_cnt_reg <= '0;
        else if (ctl.sqrt_step)
            sqrt_cnt_reg <= sqrt_cnt_reg + 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sqrt_init)
        begin
            rn_reg  <= acc_reg;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (ctl.sqrt_step)
        begin
            if (rn_reg >= trial)
            begin
                rn_reg  <= rn_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [1:0]          comp_k_reg;
    logic [3:0]          div_cnt_reg;
    logic [31:0]         rem_reg;
    logic [15:0]         low_reg;
    logic [15:0]         q_reg;
    logic [31:0]         root;
    logic [30:0]         div_t;
    logic                div_sg;
    logic [NUM_W-1:0]    numer;
    logic [32:0]         rem2;
    logic [15:0]         qc;
    logic signed [Q15_BITS-1:0] unit_reg [3];

    assign root = res_reg[31:0];

    always_comb
    begin
        case (comp_k_reg)
            2'd1:
            begin
                div_t = t_reg[1][30:0]; div_sg = sg_reg[1];
            end
            2'd2:
            begin
                div_t = t_reg[2][30:0]; div_sg = sg_reg[2];
            end
            default:
            begin
                div_t = t_reg[0][30:0]; div_sg = sg_reg[0];
            end
        endcase
        numer = (NUM_W'(div_t) << 15) + NUM_W'(root >> 1);
        rem2  = {rem_reg, low_reg[15]};
        qc    = q_reg[15] ? 16'h7FFF : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_k_reg  <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (ctl.norm_load)
                comp_k_reg <= '0;
            else if (ctl.div_store)
                comp_k_reg <= comp_k_reg + 2'd1;
            if (ctl.div_init)
                div_cnt_reg <= '0;
            else if (ctl.div_step)
                div_cnt_reg <= div_cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_init)
        begin
            rem_reg <= numer[NUM_W-1:16];
            low_reg <= numer[15:0];
            q_reg   <= '0;
        end
        else if (ctl.div_step)
        begin
            if (rem2 >= {1'b0, root})
            begin
                rem_reg <= 32'(rem2 - {1'b0, root});
                q_reg   <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[31:0];
                q_reg   <= {q_reg[14:0], 1'b0};
            end
            low_reg <= {low_reg[14:0], 1'b0};
        end
        if (ctl.div_store)
        begin
            case (comp_k_reg)
                2'd0:    unit_reg[0] <= div_sg ? -$signed(qc) : $signed(qc);
                2'd1:    unit_reg[1] <= div_sg ? -$signed(qc) : $signed(qc);
                default: unit_reg[2] <= div_sg ? -$signed(qc) : $signed(qc);
            endcase
        end
    end

    // output register
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] out_idx_reg;
    logic [Q15_BITS-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic                  out_zero_reg;
    logic                  zflag;

    assign zflag = !a_ok || (mx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_idx_reg  <= ia_reg;
            out_zero_reg <= zflag;
            out_x_reg    <= zflag ? '0 : unit_reg[0];
            out_y_reg    <= zflag ? '0 : unit_reg[1];
            out_z_reg    <= zflag ? '0 : unit_reg[2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_z_reg, out_y_reg, out_x_reg, out_idx_reg};
    assign m_tuser  = out_zero_reg;

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.a_ok      = a_ok;
        stat.face_ok   = a_ok && in_range(ib_reg) && in_range(ic_reg);
        stat.mul_last  = (mul_k_reg == 3'(NUM_PRODUCTS - 1));
        stat.norm_done = !big && mx_reg[30];
        stat.zero      = (mx_reg == '0);
        stat.sq_last   = (sq_k_reg == 2'd3);
        stat.sqrt_last = (sqrt_cnt_reg == 5'(SQRT_STEPS - 1));
        stat.div_last  = (div_cnt_reg == 4'(DIV_STEPS - 1));
        stat.comp_last = (comp_k_reg == 2'd2);
        stat.out_full  = out_valid_reg;
    end

endmodule

FILE: hdl/area_weighted_vertex_normals_top.sv
// ---------------------------------------------------------------------------
// area_weighted_vertex_normals_top
// Vertex table with area-weighted normal accumulation and unit normal read.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel takes one command per beat: set position, displace
//   position, add face, or read normal. Only read normal produces a master
//   beat: vertex index and Q1.15 unit normal in m_tdata, the zero flag
//   (zero sum or index beyond the table) in m_tuser.
//   One command is worked on at a time; s_tready is high only while idle.
//   Set or displace reads and rewrites the position; a face makes three
//   table reads, six terms through the one shared multiplier and three
//   read-modify-writes of the sum table. A normal read runs the
//   one-bit-a-cycle normalising shift, the 32-step root and three
//   16-step divisions; a zero sum skips the root and divisions, and an
//   index beyond the table goes straight to the output.
//   The result sits in an output register; a command that makes no result
//   is still taken while it waits, a further read holds until it drains.
//   Reset clears the sequencer and output valid; the tables are not
//   cleared, so a vertex must be set before it is used.
// ---------------------------------------------------------------------------
module area_weighted_vertex_normals_top import awvn_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, vertex_a, vertex_b, vertex_c, coord_x, coord_y, coord_z
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertex_index, unit_x, unit_y, unit_z
    output logic [63:0]  m_tdata,
    // zero_normal
    output logic         m_tuser
);

    awvn_cmd_t  ctl;
    awvn_stat_t stat;

    awvn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    awvn_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .ctl      (ctl),
        .stat     (stat)
    );

endmodule

FILE: dv/area_weighted_vertex_normals_top_test.sv
// ---------------------------------------------------------------------------
// area_weighted_vertex_normals_top_test
// Drives set, displace, face and read commands into the vertex normal block.
// It keeps its own copy of the position and normal-sum tables, predicts
// every unit normal read, and checks each master beat field by field.
// Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module area_weighted_vertex_normals_top_test;
    import awvn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VERTS  = 1024;
    localparam int IDLE_LIMIT = 5000;
    localparam int RAND_ITEMS = 1390;
    localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] C_MIN = -24'sh800000;
    localparam longint SUM_HI = (64'sd1 <<< 55) - 1;
    localparam longint SUM_LO = -(64'sd1 <<< 55);

    typedef struct {
        cmd_code_t                 cmd;
        logic [INDEX_BITS-1:0]     a;
        logic [INDEX_BITS-1:0]     b;
        logic [INDEX_BITS-1:0]     c;
        logic signed [23:0]        x;
        logic signed [23:0]        y;
        logic signed [23:0]        z;
    } command_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] vertex_index;
        logic signed [15:0]    unit_x;
        logic signed [15:0]    unit_y;
        logic signed [15:0]    unit_z;
        logic                  zero_normal;
    } normal_beat_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    longint       pos_tab [NUM_VERTS][3];
    longint       sum_tab [NUM_VERTS][3];
    bit           vertex_known [NUM_VERTS];
    int           known_list[$];
    normal_beat_t pending_normals[$];
    int           mismatch_count;
    int           idle_cycles;
    int           hold_cnt;
    bit           quiet;

    area_weighted_vertex_normals_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sat_sum(longint v);
        if (v > SUM_HI)
            return SUM_HI;
        if (v < SUM_LO)
            return SUM_LO;
        return v;
    endfunction

    function automatic longint sat_coord(longint v);
        if (v > longint'(C_MAX))
            return longint'(C_MAX);
        if (v < longint'(C_MIN))
            return longint'(C_MIN);
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic normal_beat_t unit_normal_of(int v);
        longint          sv [3];
        longint unsigned t [3];
        longint unsigned mx;
        longint unsigned r;
        longint unsigned q;
        logic [15:0]     u [3];
        normal_beat_t    nb;
        nb = '0;
        nb.vertex_index = INDEX_BITS'(v);
        nb.zero_normal = 1'b1;
        mx = 0;
        for (int k = 0; k < 3; k++)
        begin
            sv[k] = sum_tab[v][k];
            t[k] = (sv[k] < 0) ? longint'(-sv[k]) : longint'(sv[k]);
            if (t[k] > mx)
                mx = t[k];
            u[k] = '0;
        end
        if (mx != 0)
        begin
            while (mx >= 64'h8000_0000)
            begin
                for (int k = 0; k < 3; k++)
                    t[k] = t[k] >> 1;
                mx = mx >> 1;
            end
            while (mx < 64'h4000_0000)
            begin
                for (int k = 0; k < 3; k++)
                    t[k] = t[k] << 1;
                mx = mx << 1;
            end
            r = int_sqrt(t[0] * t[0] + t[1] * t[1] + t[2] * t[2]);
            for (int k = 0; k < 3; k++)
            begin
                q = (t[k] * 32768 + r / 2) / r;
                if (q > 32767)
                    q = 32767;
                u[k] = (sv[k] < 0) ? -q[15:0] : q[15:0];
            end
            nb.zero_normal = 1'b0;
        end
        nb.unit_x = u[0];
        nb.unit_y = u[1];
        nb.unit_z = u[2];
        return nb;
    endfunction

    task automatic apply_command(command_t cm);
        longint p [3];
        longint uv [3];
        longint wv [3];
        longint nv [3];
        int     corner [3];
        case (cm.cmd)
            CMD_SET_POS, CMD_DISPLACE:
            begin
                p[0] = longint'(cm.x);
                p[1] = longint'(cm.y);
                p[2] = longint'(cm.z);
                for (int k = 0; k < 3; k++)
                begin
                    if (cm.cmd == CMD_DISPLACE)
                        p[k] = p[k] + pos_tab[cm.a][k];
                    pos_tab[cm.a][k] = sat_coord(p[k]);
                    sum_tab[cm.a][k] = 0;
                end
            end
            CMD_ADD_FACE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    uv[k] = pos_tab[cm.b][k] - pos_tab[cm.a][k];
                    wv[k] = pos_tab[cm.c][k] - pos_tab[cm.b][k];
                end
                nv[0] = sat_sum(uv[1] * wv[2] - uv[2] * wv[1]);
                nv[1] = sat_sum(uv[2] * wv[0] - uv[0] * wv[2]);
                nv[2] = sat_sum(uv[0] * wv[1] - uv[1] * wv[0]);
                corner[0] = int'(cm.a);
                corner[1] = int'(cm.b);
                corner[2] = int'(cm.c);
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        sum_tab[corner[j]][k] = sat_sum(sum_tab[corner[j]][k] + nv[k]);
            end
            default:
                pending_normals.push_back(unit_normal_of(int'(cm.a)));
        endcase
    endtask

    task automatic send_command(command_t cm);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cm.z, cm.y, cm.x, cm.c, cm.b, cm.a, cm.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        if ((cm.cmd == CMD_SET_POS) && !vertex_known[cm.a])
        begin
            vertex_known[cm.a] = 1'b1;
            known_list.push_back(int'(cm.a));
        end
        apply_command(cm);
    endtask

    task automatic drain_normals();
        s_tvalid <= 1'b0;
        while (pending_normals.size() > 0)
            @(posedge clk);
    endtask

    function automatic command_t make_command(cmd_code_t cmd, int a, int b, int c,
                                              logic signed [23:0] x,
                                              logic signed [23:0] y,
                                              logic signed [23:0] z);
        command_t cm;
        cm.cmd = cmd;
        cm.a = INDEX_BITS'(a);
        cm.b = INDEX_BITS'(b);
        cm.c = INDEX_BITS'(c);
        cm.x = x;
        cm.y = y;
        cm.z = z;
        return cm;
    endfunction

    function automatic logic signed [23:0] random_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
            2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default: return $signed(24'($urandom_range(0, 200000))) - 24'sd100000;
        endcase
    endfunction

    function automatic int any_known();
        return known_list[$urandom_range(0, known_list.size() - 1)];
    endfunction

    task automatic send_simple(cmd_code_t cmd, int a, int b, int c,
                               logic signed [23:0] x, logic signed [23:0] y,
                               logic signed [23:0] z);
        send_command(make_command(cmd, a, b, c, x, y, z));
    endtask

    task automatic test_directed();
        send_simple(CMD_SET_POS, 0, 1023, 0, C_MAX, C_MAX, C_MAX);
        send_simple(CMD_SET_POS, 1023, 0, 1023, C_MIN, C_MIN, C_MIN);
        send_simple(CMD_SET_POS, 512, 341, 682, C_MAX, 24'sd0, C_MIN);
        send_simple(CMD_SET_POS, 341, 682, 341, 24'sd1, -24'sd1, 24'sd5);
        send_simple(CMD_SET_POS, 682, 0, 0, -24'sd3, 24'sd7, 24'sd2);
        send_simple(CMD_READ_NORMAL, 682, 1023, 1023, C_MIN, C_MAX, C_MIN);
        send_simple(CMD_ADD_FACE, 0, 1023, 512, C_MIN, C_MIN, C_MIN);
        send_simple(CMD_READ_NORMAL, 0, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_READ_NORMAL, 1023, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_READ_NORMAL, 512, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_ADD_FACE, 341, 341, 682, C_MAX, C_MAX, C_MAX);
        send_simple(CMD_ADD_FACE, 341, 682, 512, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_READ_NORMAL, 341, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_READ_NORMAL, 682, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_DISPLACE, 0, 0, 0, C_MAX, C_MAX, 24'sd1);
        send_simple(CMD_DISPLACE, 1023, 0, 0, C_MIN, -24'sd1, C_MIN);
        send_simple(CMD_DISPLACE, 512, 1023, 1023, 24'sd10, 24'sd20, 24'sd30);
        send_simple(CMD_READ_NORMAL, 0, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_ADD_FACE, 0, 512, 1023, 24'sd0, 24'sd0, 24'sd0);
        send_simple(CMD_READ_NORMAL, 512, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        drain_normals();
    endtask

    task automatic test_sum_saturation();
        send_simple(CMD_SET_POS, 1, 0, 0, C_MIN, C_MIN, 24'sd0);
        send_simple(CMD_SET_POS, 2, 0, 0, C_MAX, C_MIN, 24'sd0);
        send_simple(CMD_SET_POS, 3, 0, 0, C_MAX, C_MAX, 24'sd0);
        send_simple(CMD_SET_POS, 4, 0, 0, C_MIN, C_MIN, 24'sd5);
        send_simple(CMD_SET_POS, 5, 0, 0, C_MAX, C_MIN, -24'sd5);
        send_simple(CMD_SET_POS, 6, 0, 0, C_MAX, C_MAX, 24'sd9);
        for (int n = 0; n < 140; n++)
        begin
            send_simple(CMD_ADD_FACE, 1, 2, 3, 24'sd0, 24'sd0, 24'sd0);
            send_simple(CMD_ADD_FACE, 4, 6, 5, 24'sd0, 24'sd0, 24'sd0);
        end
        for (int v = 1; v <= 6; v++)
            send_simple(CMD_READ_NORMAL, v, 0, 0, 24'sd0, 24'sd0, 24'sd0);
        drain_normals();
    endtask

    task automatic test_random_mesh();
        int       roll;
        command_t cm;
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if ((i % 150) == 0)
                quiet = $urandom_range(0, 3) == 0;
            if ((i % 250) == 249)
                drain_normals();
            roll = $urandom_range(0, 99);
            cm = make_command(CMD_SET_POS, $urandom_range(0, NUM_VERTS - 1),
                              $urandom_range(0, NUM_VERTS - 1),
                              $urandom_range(0, NUM_VERTS - 1),
                              random_coord(), random_coord(), random_coord());
            if (roll < 12)
                cm.cmd = CMD_SET_POS;
            else if (roll < 18)
            begin
                cm.cmd = CMD_DISPLACE;
                cm.a = INDEX_BITS'(any_known());
            end
            else if (roll < 72)
            begin
                cm.cmd = CMD_ADD_FACE;
                cm.a = INDEX_BITS'(any_known());
                cm.b = INDEX_BITS'(any_known());
                cm.c = INDEX_BITS'(any_known());
                if (roll < 22)
                    cm.c = cm.a;
            end
            else
            begin
                cm.cmd = CMD_READ_NORMAL;
                cm.a = INDEX_BITS'(any_known());
            end
            send_command(cm);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
    endtask

    task automatic report_field(string name, longint exp_v, longint got_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            hold_cnt <= quiet ? 0 : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        normal_beat_t exp_b;
        normal_beat_t got_b;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_b.vertex_index = m_tdata[9:0];
            got_b.unit_x = m_tdata[25:10];
            got_b.unit_y = m_tdata[41:26];
            got_b.unit_z = m_tdata[57:42];
            got_b.zero_normal = m_tuser;
            if (pending_normals.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected beat, expected none, actual index %0d",
                         $time, got_b.vertex_index);
            end
            else
            begin
                exp_b = pending_normals.pop_front();
                if (exp_b.vertex_index != got_b.vertex_index)
                    report_field("vertex_index", longint'(exp_b.vertex_index),
                                 longint'(got_b.vertex_index));
                if (exp_b.unit_x != got_b.unit_x)
                    report_field("unit_x", longint'(exp_b.unit_x), longint'(got_b.unit_x));
                if (exp_b.unit_y != got_b.unit_y)
                    report_field("unit_y", longint'(exp_b.unit_y), longint'(got_b.unit_y));
                if (exp_b.unit_z != got_b.unit_z)
                    report_field("unit_z", longint'(exp_b.unit_z), longint'(got_b.unit_z));
                if (exp_b.zero_normal != got_b.zero_normal)
                    report_field("zero_normal", longint'(exp_b.zero_normal),
                                 longint'(got_b.zero_normal));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_sum_saturation();
        test_random_mesh();
        while (pending_normals.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
hdl/awvn_pkg.sv
hdl/awvn_ctrl.sv
hdl/awvn_datapath.sv
hdl/area_weighted_vertex_normals_top.sv
dv/area_weighted_vertex_normals_top_test.sv
